// ===== src/wav_pcm_stream_parser_unit_macros.svh =====
// Assertion macros shared by the checker of the WAV PCM stream parser.
// No dependencies; take in with an include before use.
`ifndef WAV_PCM_STREAM_PARSER_UNIT_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WPSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WPSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wpsp_pkg.sv =====
// Shared types and constants of the WAV PCM stream parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wpsp_pkg;

  // Result status codes
  localparam logic [3:0] ST_SAMPLE  = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_TAG     = 4'd2;
  localparam logic [3:0] ST_NOTPCM  = 4'd3;
  localparam logic [3:0] ST_WIDTH   = 4'd4;
  localparam logic [3:0] ST_FMTSIZE = 4'd5;
  localparam logic [3:0] ST_NODATA  = 4'd6;
  localparam logic [3:0] ST_OVERRUN = 4'd7;
  localparam logic [3:0] ST_EMPTY   = 4'd8;

  // Register index of file_length (address bit 2)
  localparam logic REG_FILE_LENGTH = 1'b0;

  // Chunk tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE_LEN = 32'd44;
  localparam logic [31:0] MIN_FMT_SIZE = 32'd16;

  typedef struct packed {
    logic [15:0] pcm_sample;
    logic [3:0]  status;
    logic        last;
    logic [31:0] rate_out;
    logic [15:0] channel_count;
  } wpsp_result_t;

endpackage
`default_nettype wire

// ===== src/wpsp_cfg_regs.sv =====
// Configuration register file of the WAV PCM stream parser (file length).
// Depends on wpsp_pkg for the register index.
`timescale 1ns / 1ps
`default_nettype none
module wpsp_cfg_regs
  import wpsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] file_length
);

  logic [31:0] file_length_r;
  logic [31:0] file_length_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    file_length_nxt = file_length_r;
    if (wr_en && (paddr[2] == REG_FILE_LENGTH)) begin
      file_length_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else begin
      file_length_r <= file_length_nxt;
    end
  end

  // paddr[1:0] are byte lanes and do not select a register
  assign prdata      = (paddr[2] == REG_FILE_LENGTH) ? file_length_r : 32'd0;
  assign file_length = file_length_r;

endmodule
`default_nettype wire

// ===== src/wpsp_parse_core.sv =====
// Parse state and per-byte update of the WAV PCM stream parser.
// Depends on wpsp_pkg for status codes, tags and the result type.
`timescale 1ns / 1ps
`default_nettype none
module wpsp_parse_core
  import wpsp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   file_byte,
  input  wire logic [31:0]  file_length,
  output logic              res_valid,
  output wpsp_result_t      res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_ID,
    PH_SIZE_DATA,
    PH_SIZE_OTHER,
    PH_DATA,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] fmt_len_r, fmt_len_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        w16_r, w16_nxt;
  logic [32:0] left_r, left_nxt;
  logic [7:0]  low_r, low_nxt;

  logic [31:0] tag_in;
  logic [32:0] left_dec;
  logic [15:0] hdr_width;
  logic [31:0] fmt_skip;
  logic [33:0] fmt_end;
  logic [32:0] chunk_skip;
  logic [33:0] chunk_end;
  logic [33:0] data_end;
  logic [31:0] data_n;

  assign tag_in     = {file_byte, tag_r[31:8]};
  assign left_dec   = left_r - 33'd1;
  assign hdr_width  = tag_in[31:16];
  assign fmt_skip   = fmt_len_r - MIN_FMT_SIZE;
  assign fmt_end    = {2'b00, fmt_len_r} + 34'd28;
  assign chunk_skip = {1'b0, tag_in} + {32'd0, tag_in[0]};
  assign chunk_end  = {2'b00, pos_r} + {1'b0, chunk_skip} + 34'd9;
  assign data_end   = {2'b00, pos_r} + {2'b00, tag_in} + 34'd1;
  assign data_n     = w16_r ? {tag_in[31:1], 1'b0} : tag_in;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    fmt_len_nxt  = fmt_len_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    w16_nxt      = w16_r;
    left_nxt     = left_r;
    low_nxt      = low_r;
    res_valid    = 1'b0;
    res          = '0;

    if (step && (phase_r != PH_DONE)) begin
      pos_nxt = pos_r + 32'd1;
      tag_nxt = tag_in;
      unique case (phase_r)
        PH_HEADER: begin
          // header phase never sees a position above 35
          unique case (pos_r[5:0])
            6'd0: begin
              if (file_length < MIN_FILE_LEN) begin
                res_valid = 1'b1;
                res.status = ST_SHORT;
              end
            end
            6'd3: begin
              if (tag_in != TAG_RIFF) begin
                res_valid = 1'b1;
                res.status = ST_TAG;
              end
            end
            6'd11: begin
              if (tag_in != TAG_WAVE) begin
                res_valid = 1'b1;
                res.status = ST_TAG;
              end
            end
            6'd15: begin
              if (tag_in != TAG_FMT) begin
                res_valid = 1'b1;
                res.status = ST_TAG;
              end
            end
            6'd19: begin
              fmt_len_nxt = tag_in;
              if (tag_in < MIN_FMT_SIZE) begin
                res_valid = 1'b1;
                res.status = ST_FMTSIZE;
              end
            end
            6'd21: begin
              if (tag_in[31:16] != 16'd1) begin
                res_valid = 1'b1;
                res.status = ST_NOTPCM;
              end
            end
            6'd23: chans_nxt = tag_in[31:16];
            6'd27: rate_nxt = tag_in;
            6'd35: begin
              if ((hdr_width != 16'd8) && (hdr_width != 16'd16)) begin
                res_valid = 1'b1;
                res.status = ST_WIDTH;
              end else begin
                w16_nxt = (hdr_width == 16'd16);
                if (fmt_end > {2'b00, file_length}) begin
                  res_valid = 1'b1;
                  res.status = ST_NODATA;
                end else if (fmt_skip == 32'd0) begin
                  phase_nxt = PH_ID;
                  left_nxt  = 33'd4;
                end else begin
                  phase_nxt = PH_SKIP;
                  left_nxt  = {1'b0, fmt_skip};
                end
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          left_nxt = left_dec;
          if (left_dec == 33'd0) begin
            phase_nxt = PH_ID;
            left_nxt  = 33'd4;
          end
        end
        PH_ID: begin
          left_nxt = left_dec;
          if (left_dec == 33'd0) begin
            phase_nxt = (tag_in == TAG_DATA) ? PH_SIZE_DATA : PH_SIZE_OTHER;
            left_nxt  = 33'd4;
          end
        end
        PH_SIZE_OTHER: begin
          left_nxt = left_dec;
          if (left_dec == 33'd0) begin
            // size plus pad byte to the next chunk header
            if (chunk_end > {2'b00, file_length}) begin
              res_valid = 1'b1;
              res.status = ST_NODATA;
            end else if (chunk_skip == 33'd0) begin
              phase_nxt = PH_ID;
              left_nxt  = 33'd4;
            end else begin
              phase_nxt = PH_SKIP;
              left_nxt  = chunk_skip;
            end
          end
        end
        PH_SIZE_DATA: begin
          left_nxt = left_dec;
          if (left_dec == 33'd0) begin
            if (data_end > {2'b00, file_length}) begin
              res_valid = 1'b1;
              res.status = ST_OVERRUN;
            end else if (data_n == 32'd0) begin
              res_valid         = 1'b1;
              res.status        = ST_EMPTY;
              res.rate_out      = rate_r;
              res.channel_count = chans_r;
            end else begin
              phase_nxt = PH_DATA;
              left_nxt  = {1'b0, data_n};
            end
          end
        end
        PH_DATA: begin
          left_nxt = left_dec;
          if (w16_r && left_dec[0]) begin
            // hold the low byte of a 16-bit pair
            low_nxt = file_byte;
          end else begin
            res_valid         = 1'b1;
            res.status        = ST_SAMPLE;
            res.last          = (left_dec == 33'd0);
            res.rate_out      = rate_r;
            res.channel_count = chans_r;
            res.pcm_sample    = w16_r ? {file_byte, low_r}
                                      : {file_byte ^ 8'h80, 8'h00};
            if (left_dec == 33'd0) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        default: ;
      endcase
      // every non-sample result ends the parse
      if (res_valid && (res.status != ST_SAMPLE)) begin
        res.last  = 1'b1;
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      tag_r      <= '0;
      fmt_len_r  <= '0;
      chans_r    <= '0;
      rate_r     <= '0;
      w16_r      <= 1'b0;
      left_r     <= '0;
      low_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      tag_r      <= tag_nxt;
      fmt_len_r  <= fmt_len_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      w16_r      <= w16_nxt;
      left_r     <= left_nxt;
      low_r      <= low_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/wav_pcm_stream_parser_unit.sv =====
// Top level of the WAV PCM stream parser: input register, parse core, result register.
// Depends on wpsp_pkg, wpsp_cfg_regs and wpsp_parse_core.
//
//  channel | direction | protocol        | payload
//  in_     | slave     | tvalid/tready   | tdata[7:0] file_byte
//  out_    | master    | tvalid/tready   | tdata pcm_sample/rate/channels, tuser status, tlast
//  cfg_    | slave     | APB, pready = 1 | register 0 file_length at byte address 0
//
// One byte per cycle sustained while results are taken; a request is taken into
// the input register at acceptance and its result reaches the result register
// when the core steps on it, after one pass through the core.
// The rate is set by the state update in the parse core, done once per byte.
// Reset is synchronous and active low; it clears file_length and restarts the parse.
// A stalled result holds the core; the input register still takes one request.
`timescale 1ns / 1ps
`default_nettype none
module wav_pcm_stream_parser_unit
  import wpsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] file_byte
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,     // [15:0] pcm_sample, [47:16] rate_out,
                                          // [63:48] channel_count
  output logic      [3:0]  out_tuser,     // [3:0] status
  output logic             out_tlast,     // last
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic         in_v_r, in_v_nxt;
  logic [7:0]   in_byte_r, in_byte_nxt;
  logic         out_v_r, out_v_nxt;
  wpsp_result_t out_res_r, out_res_nxt;
  logic         step;
  logic         res_valid;
  wpsp_result_t res;
  logic [31:0]  file_length;

  wpsp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .file_length (file_length)
  );

  // Advance the held byte whenever the result register can take its outcome
  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  wpsp_parse_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .file_byte   (in_byte_r),
    .file_length (file_length),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    in_v_nxt    = in_v_r;
    in_byte_nxt = in_byte_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt    = 1'b1;
      in_byte_nxt = in_tdata;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt   = out_v_r;
    out_res_nxt = out_res_r;
    if (step && res_valid) begin
      out_v_nxt   = 1'b1;
      out_res_nxt = res;
    end else if (out_tready) begin
      // drop the result once taken
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.channel_count, out_res_r.rate_out, out_res_r.pcm_sample};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule
`default_nettype wire

// ===== src/wpsp_checker.sv =====
// Port-level checker of the WAV PCM stream parser, bound to the top level.
// Depends on wpsp_pkg and wav_pcm_stream_parser_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "wav_pcm_stream_parser_unit_macros.svh"
module wpsp_checker
  import wpsp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);

  `WPSP_ASSERT_IMP(a_status_last, clk, rst_n, out_tvalid && (out_tuser != ST_SAMPLE), out_tlast, "status result without tlast")
  `WPSP_ASSERT_IMP(a_err_no_hdr, clk, rst_n, out_tvalid && (out_tuser != ST_SAMPLE) && (out_tuser != ST_EMPTY), out_tdata[63:16] == 48'd0, "error result carries header values")
  `WPSP_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tuser <= ST_EMPTY, "status code out of range")
  `WPSP_ASSERT_NXT(a_quiet_after_last, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid, "result after the final one")

endmodule

bind wav_pcm_stream_parser_unit wpsp_checker u_wpsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
